// File: src/blkc_pkg.sv
// package for the batched lru key cache
// holds sizes, word layout and the sequencer state type; no dependencies
`default_nettype none
package blkc_pkg;
  localparam int MaxEntries = 1024;
  localparam int SlotBits   = 10;
  localparam int CntBits    = SlotBits + 1;
  localparam int BatchSize  = 26;
  localparam int PosBits    = 5;
  localparam int RowBits    = 24;
  localparam int KeyBits    = PosBits + RowBits;
  localparam int AgeBits    = 10;
  localparam int CapBits    = 11;
  localparam int WordBits   = 1 + AgeBits + KeyBits;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_EMIT, S_ALOAD, S_AKEY, S_ASCAN,
    S_ADEC, S_AUPD, S_ANEXT
  } state_t;
endpackage
`default_nettype wire

// File: src/batched_lru_key_cache_top.sv
// top level of the batched lru key cache: tag store, sweep sequencer, batch updates
// depends on blkc_pkg
`default_nettype none
// Fully associative LRU tag engine. Each row word is keyed with its position in
// the batch and looked up by one sweep of the 1024-entry tag memory, one entry a
// cycle. An item is taken only in idle, then swept through the read pipeline, and
// its result is loaded once the result register is free; a new word is not taken
// before that. After the last item of a batch each of the 26 pending keys is
// applied in order with a search sweep and, unless a hit key has already been
// evicted, an age-update sweep. After reset and after every capacity write a
// clearing pass runs before the first word is taken. The last item of a batch is
// flagged on out_tlast.
module batched_lru_key_cache_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // row_id[23:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // hit[0], hit_slot[10:1], hits_so_far[15:11], all_hit[16]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);
  blkc_pkg::state_t state_r, state_nxt;

  logic [blkc_pkg::WordBits-1:0] mem [blkc_pkg::MaxEntries];
  logic [blkc_pkg::WordBits-1:0] q_r;
  logic [blkc_pkg::RowBits:0]    pend [blkc_pkg::BatchSize];
  logic [blkc_pkg::RowBits:0]    pq_r;

  logic [blkc_pkg::CntBits-1:0]  cnt_r;
  logic                          rd_v_r;
  logic [blkc_pkg::SlotBits-1:0] rd_a_r;
  logic                          sweep_done;
  logic                          sweep_on;

  logic [blkc_pkg::CapBits-1:0]  cap_r, occ_r, effcap;
  logic [blkc_pkg::PosBits-1:0]  pos_r, p_r, hits_r, hits_inc;
  logic [blkc_pkg::RowBits-1:0]  row_r;
  logic [blkc_pkg::KeyBits-1:0]  key_r;
  logic                          mode_hit_r;

  logic                          match_f_r, old_f_r, free_f_r;
  logic [blkc_pkg::SlotBits-1:0] match_s_r, old_s_r, free_s_r, tgt_r;
  logic [blkc_pkg::AgeBits-1:0]  match_a_r, old_a_r;

  logic                          q_valid;
  logic [blkc_pkg::AgeBits-1:0]  q_age;
  logic [blkc_pkg::KeyBits-1:0]  q_key;
  logic                          go_upd, occ_inc;

  logic                          we;
  logic [blkc_pkg::SlotBits-1:0] wa;
  logic [blkc_pkg::WordBits-1:0] wd;

  logic                          out_v_r, out_last_r, out_hit_r, out_all_r;
  logic [blkc_pkg::SlotBits-1:0] out_slot_r;
  logic [blkc_pkg::PosBits-1:0]  out_hits_r;

  assign q_valid    = q_r[blkc_pkg::WordBits-1];
  assign q_age      = q_r[blkc_pkg::WordBits-2 -: blkc_pkg::AgeBits];
  assign q_key      = q_r[blkc_pkg::KeyBits-1:0];
  assign sweep_done = cnt_r[blkc_pkg::CntBits-1] && !rd_v_r;
  assign hits_inc   = hits_r + blkc_pkg::PosBits'(match_f_r);
  assign sweep_on   = (state_r == blkc_pkg::S_CLEAR) || (state_r == blkc_pkg::S_SCAN) ||
                      (state_r == blkc_pkg::S_ASCAN) || (state_r == blkc_pkg::S_AUPD);

  // effective capacity: zero acts as one, clipped to the store size
  always_comb begin
    effcap = cap_r;
    if (cap_r == '0) effcap = blkc_pkg::CapBits'(1);
    if (cap_r > blkc_pkg::CapBits'(blkc_pkg::MaxEntries))
      effcap = blkc_pkg::CapBits'(blkc_pkg::MaxEntries);
  end

  // apply decision: which slot gets written this key
  always_comb begin
    go_upd  = 1'b0;
    occ_inc = 1'b0;
    if (mode_hit_r) begin
      go_upd = match_f_r;
    end else if (occ_r >= effcap && old_f_r) begin
      go_upd = 1'b1;
    end else if (free_f_r) begin
      go_upd  = 1'b1;
      occ_inc = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blkc_pkg::S_CLEAR: if (cnt_r[blkc_pkg::CntBits-1]) state_nxt = blkc_pkg::S_IDLE;
      blkc_pkg::S_IDLE: begin
        if (cfg_valid) state_nxt = blkc_pkg::S_CLEAR;
        else if (in_tvalid) state_nxt = blkc_pkg::S_SCAN;
      end
      blkc_pkg::S_SCAN: if (sweep_done) state_nxt = blkc_pkg::S_EMIT;
      blkc_pkg::S_EMIT: begin
        if (!out_v_r || out_tready)
          state_nxt = (pos_r == blkc_pkg::PosBits'(blkc_pkg::BatchSize - 1)) ?
                      blkc_pkg::S_ALOAD : blkc_pkg::S_IDLE;
      end
      blkc_pkg::S_ALOAD: state_nxt = blkc_pkg::S_AKEY;
      blkc_pkg::S_AKEY:  state_nxt = blkc_pkg::S_ASCAN;
      blkc_pkg::S_ASCAN: if (sweep_done) state_nxt = blkc_pkg::S_ADEC;
      blkc_pkg::S_ADEC:  state_nxt = go_upd ? blkc_pkg::S_AUPD : blkc_pkg::S_ANEXT;
      blkc_pkg::S_AUPD:  if (sweep_done) state_nxt = blkc_pkg::S_ANEXT;
      blkc_pkg::S_ANEXT: begin
        state_nxt = (p_r == blkc_pkg::PosBits'(blkc_pkg::BatchSize - 1)) ?
                    blkc_pkg::S_IDLE : blkc_pkg::S_ALOAD;
      end
      default: state_nxt = blkc_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready = (state_r == blkc_pkg::S_IDLE) && !cfg_valid;
    cfg_ready = (state_r == blkc_pkg::S_IDLE);
  end

  // tag memory write port: clearing pass and age-update sweep
  always_comb begin
    we = 1'b0;
    wa = rd_a_r;
    wd = q_r;
    if (state_r == blkc_pkg::S_CLEAR) begin
      we = !cnt_r[blkc_pkg::CntBits-1];
      wa = cnt_r[blkc_pkg::SlotBits-1:0];
      wd = '0;
    end else if (state_r == blkc_pkg::S_AUPD && rd_v_r) begin
      if (rd_a_r == tgt_r) begin
        we = 1'b1;
        wd = {1'b1, blkc_pkg::AgeBits'(0), key_r};
      end else if (q_valid) begin
        we = 1'b1;
        if (!mode_hit_r || q_age < match_a_r)
          wd = {1'b1, q_age + blkc_pkg::AgeBits'(1), q_key};
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    q_r <= mem[cnt_r[blkc_pkg::SlotBits-1:0]];
    if (state_r == blkc_pkg::S_EMIT && (!out_v_r || out_tready))
      pend[pos_r] <= {match_f_r, row_r};
    pq_r <= pend[p_r];
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blkc_pkg::S_CLEAR;
      cap_r   <= blkc_pkg::CapBits'(blkc_pkg::MaxEntries);
      occ_r   <= '0;
      pos_r   <= '0;
      hits_r  <= '0;
      p_r     <= '0;
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // result valid: set when a result is loaded, cleared when taken
      if (state_r == blkc_pkg::S_EMIT && (!out_v_r || out_tready)) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;

      // sweep counter and read pipeline
      rd_v_r <= sweep_on && !cnt_r[blkc_pkg::CntBits-1] && (state_r != blkc_pkg::S_CLEAR);
      if (sweep_on) begin
        if (!cnt_r[blkc_pkg::CntBits-1]) begin
          cnt_r  <= cnt_r + blkc_pkg::CntBits'(1);
          rd_a_r <= cnt_r[blkc_pkg::SlotBits-1:0];
        end
      end else begin
        cnt_r <= '0;
      end

      // search evaluation on each returned word
      if ((state_r == blkc_pkg::S_SCAN || state_r == blkc_pkg::S_ASCAN) && rd_v_r) begin
        if (q_valid && q_key == key_r && !match_f_r) begin
          match_f_r <= 1'b1;
          match_s_r <= rd_a_r;
          match_a_r <= q_age;
        end
        if (q_valid && (!old_f_r || q_age > old_a_r)) begin
          old_f_r <= 1'b1;
          old_s_r <= rd_a_r;
          old_a_r <= q_age;
        end
        if (!q_valid && !free_f_r) begin
          free_f_r <= 1'b1;
          free_s_r <= rd_a_r;
        end
      end

      case (state_r)
        blkc_pkg::S_IDLE: begin
          match_f_r <= 1'b0;
          old_f_r   <= 1'b0;
          free_f_r  <= 1'b0;
          if (cfg_valid) begin
            cap_r  <= cfg_data;
            occ_r  <= '0;
            pos_r  <= '0;
            hits_r <= '0;
          end else if (in_tvalid) begin
            row_r <= in_tdata;
            key_r <= {pos_r, in_tdata};
          end
        end
        blkc_pkg::S_EMIT: begin
          if (!out_v_r || out_tready) begin
            out_hit_r  <= match_f_r;
            out_slot_r <= match_f_r ? match_s_r : '0;
            out_hits_r <= hits_inc;
            out_all_r  <= (hits_inc == pos_r + blkc_pkg::PosBits'(1));
            out_last_r <= (pos_r == blkc_pkg::PosBits'(blkc_pkg::BatchSize - 1));
            hits_r     <= hits_inc;
            pos_r      <= pos_r + blkc_pkg::PosBits'(1);
            p_r        <= '0;
          end
        end
        blkc_pkg::S_AKEY: begin
          key_r      <= {p_r, pq_r[blkc_pkg::RowBits-1:0]};
          mode_hit_r <= pq_r[blkc_pkg::RowBits];
          match_f_r  <= 1'b0;
          old_f_r    <= 1'b0;
          free_f_r   <= 1'b0;
        end
        blkc_pkg::S_ADEC: begin
          if (occ_inc) occ_r <= occ_r + blkc_pkg::CapBits'(1);
          if (mode_hit_r)   tgt_r <= match_s_r;
          else if (occ_inc) tgt_r <= free_s_r;
          else              tgt_r <= old_s_r;
        end
        blkc_pkg::S_ANEXT: begin
          if (p_r == blkc_pkg::PosBits'(blkc_pkg::BatchSize - 1)) begin
            pos_r  <= '0;
            hits_r <= '0;
          end else begin
            p_r <= p_r + blkc_pkg::PosBits'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result port
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_all_r, out_hits_r, out_slot_r, out_hit_r};
endmodule
`default_nettype wire
